// ===== hdl/triangle_to_shaded_vertices_macros.svh =====
// assertion macros shared by the block
`ifndef TRIANGLE_TO_SHADED_VERTICES_MACROS_SVH
`define TRIANGLE_TO_SHADED_VERTICES_MACROS_SVH

// same-cycle implication
`define TSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tsv_pkg.sv =====
package tsv_pkg;

  localparam int NormW    = 16;
  localparam int PosW     = 32;
  localparam int ColorW   = 32;
  localparam int TotalW   = 24;
  localparam int Corners  = 3;
  localparam int InDataW  = 3 * NormW + 3 * Corners * PosW;
  localparam int OutDataW = ColorW + 3 * NormW + 3 * PosW;
  localparam int OutUserW = 3;
  localparam int PaddrW   = 3;

  // register byte addresses
  localparam logic [PaddrW-1:0] RegTriangleTotal = 3'd0;

  // channel value when the normal has zero length
  localparam logic [7:0] ChanMid = 8'd127;
  localparam logic [7:0] Alpha   = 8'hFF;
  // 255 squared
  localparam logic [15:0] Scale2 = 16'd65025;

  // one shaded triangle waiting for the emitter
  typedef struct packed {
    logic [ColorW-1:0]             color;
    logic [2:0][NormW-1:0]         normal;
    logic [3*Corners-1:0][PosW-1:0] pos;
    logic                          last_model;
  } tri_entry_t;

  // configuration handed to the front end
  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              clear;
  } cfg_ctl_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/tsv_shade.sv =====
module tsv_shade
  import tsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_ctl_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [InDataW-1:0] in_data,
  input  q_stat_t            q_stat,
  output logic               q_push,
  output tri_entry_t         q_entry
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_DSQ   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } st_t;

  st_t state_r, state_nxt;

  logic signed [NormW-1:0]        v_r   [3];
  logic [30:0]                    sq_r  [3];
  logic [46:0]                    vk_r  [3];
  logic [7:0]                     c_r   [3];
  logic [7:0]                     tr_r  [3];
  logic [15:0]                    d2_r  [3];
  logic                           dpos_r[3];
  logic [31:0]                    s_r;
  logic [2:0]                     bit_r;
  logic [3*Corners-1:0][PosW-1:0] pos_r;
  logic                           fin_r;
  logic [TotalW-1:0]              seen_r;
  logic                           fire;
  logic                           final_tri;

  assign in_ready  = (state_r == S_IDLE);
  assign fire      = in_valid && in_ready;
  assign final_tri = (cfg.total != '0) && (seen_r == cfg.total - 1'b1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (fire) state_nxt = S_SQ;
      S_SQ:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DSQ;
      S_DSQ:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (bit_r == 3'd0) ? S_PUSH : S_DSQ;
      S_PUSH:  if (!q_stat.full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg.clear) begin
        seen_r <= '0;
      end else if (fire) begin
        seen_r <= final_tri ? '0 : seen_r + 1'b1;
      end
    end
  end

  // datapath: squares, squared length, then binary search per channel
  always_ff @(posedge clk) begin
    logic signed [31:0] p;
    logic signed [9:0]  d;
    logic signed [19:0] dd;
    logic [7:0]         t;
    logic [47:0]        prod;
    logic               ok;
    if (fire) begin
      v_r[0] <= in_data[NormW-1:0];
      v_r[1] <= in_data[2*NormW-1:NormW];
      v_r[2] <= in_data[3*NormW-1:2*NormW];
      pos_r  <= in_data[InDataW-1:3*NormW];
      fin_r  <= final_tri;
    end
    for (int k = 0; k < 3; k++) begin
      p    = v_r[k] * v_r[k];
      t    = c_r[k] | (8'd1 << bit_r);
      d    = $signed({1'b0, t, 1'b0}) - 10'sd255;
      dd   = d * d;
      prod = d2_r[k] * s_r;
      if (dpos_r[k]) begin
        ok = !v_r[k][NormW-1] && (prod <= {1'b0, vk_r[k]});
      end else begin
        ok = !v_r[k][NormW-1] || (prod >= {1'b0, vk_r[k]});
      end
      case (state_r)
        S_SQ:    sq_r[k] <= p[30:0];
        S_SCALE: begin
          vk_r[k] <= Scale2 * sq_r[k];
          c_r[k]  <= '0;
        end
        S_DSQ:   begin
          tr_r[k]   <= t;
          d2_r[k]   <= dd[15:0];
          dpos_r[k] <= !d[9] && (d != '0);
        end
        S_CMP:   if (ok) c_r[k] <= tr_r[k];
        default: ;
      endcase
    end
    case (state_r)
      S_SUM:   s_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      S_SCALE: bit_r <= 3'd7;
      S_CMP:   bit_r <= bit_r - 3'd1;
      default: ;
    endcase
  end

  // queue write
  assign q_push = (state_r == S_PUSH) && !q_stat.full;
  always_comb begin
    q_entry.color = (s_r == '0) ? {Alpha, ChanMid, ChanMid, ChanMid}
                                : {Alpha, c_r[2], c_r[1], c_r[0]};
    q_entry.normal     = {v_r[2], v_r[1], v_r[0]};
    q_entry.pos        = pos_r;
    q_entry.last_model = fin_r;
  end

endmodule

// ===== hdl/tsv_queue.sv =====
module tsv_queue
  import tsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tri_entry_t wr_entry,
  input  logic       pop,
  output tri_entry_t rd_entry,
  output q_stat_t    stat
);

  tri_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_entry   = mem_r[rp_r];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/tsv_emit.sv =====
module tsv_emit
  import tsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  q_stat_t             q_stat,
  input  tri_entry_t          q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutDataW-1:0] out_data,
  output logic                out_last,
  output logic [OutUserW-1:0] out_user
);

  tri_entry_t cur_r;
  logic       have_r;
  logic [1:0] k_r;
  logic       fire;
  logic       done;

  assign fire  = have_r && out_ready;
  assign done  = fire && (k_r == 2'd2);
  assign q_pop = (!have_r || done) && !q_stat.empty;

  // record sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      k_r    <= '0;
    end else if (!have_r || done) begin
      have_r <= !q_stat.empty;
      k_r    <= '0;
    end else if (fire) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_entry;
  end

  // record fields
  always_comb begin
    logic [3*PosW-1:0] p;
    case (k_r)
      2'd0:    p = {cur_r.pos[2], cur_r.pos[1], cur_r.pos[0]};
      2'd1:    p = {cur_r.pos[5], cur_r.pos[4], cur_r.pos[3]};
      default: p = {cur_r.pos[8], cur_r.pos[7], cur_r.pos[6]};
    endcase
    out_valid = have_r;
    out_data  = {p, cur_r.normal, cur_r.color};
    out_last  = (k_r == 2'd2);
    out_user  = {(k_r == 2'd2) && cur_r.last_model, k_r};
  end

endmodule

// ===== hdl/triangle_to_shaded_vertices.sv =====
// Triangle shader: each accepted triangle (facet normal in signed fixed point,
// three raw float corner positions) yields three vertex records in corner
// order, all with the same RGBA8888 color taken from the normalized normal
// (alpha 0xFF, 127 per channel for a zero normal). The front end takes a new
// triangle only once it is through with the last one: squaring, summing and
// scaling, then an 8-step binary search on each channel with a DSQ and a CMP
// state per step, then a write into a two-entry queue that waits while the
// queue is full, and back to idle, where the next triangle is taken. The back
// end sends one record per cycle while out_tready is high. out_tuser[2] marks
// the last vertex of the model; writing triangle_total restarts the triangle count.
`include "triangle_to_shaded_vertices_macros.svh"
module triangle_to_shaded_vertices
  import tsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: normal_x, normal_y, normal_z, corner1_x..z, corner2_x..z, corner3_x..z
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // out_tdata: color, normal_x_out, normal_y_out, normal_z_out, pos_x, pos_y, pos_z
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,
  // out_tuser: corner_index[1:0], last_of_model
  output logic [OutUserW-1:0] out_tuser,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PaddrW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [TotalW-1:0] total_r;
  logic              wr;
  cfg_ctl_t          cfg;
  q_stat_t           q_stat;
  logic              q_push, q_pop;
  tri_entry_t        q_wr, q_rd;

  // register port
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == RegTriangleTotal);
  assign cfg_prdata = (cfg_paddr == RegTriangleTotal) ? {8'd0, total_r} : 32'd0;
  assign cfg.total = total_r;
  assign cfg.clear = wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (wr) begin
      total_r <= cfg_pwdata[TotalW-1:0];
    end
  end

  tsv_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  tsv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .stat     (q_stat)
  );

  tsv_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_entry   (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser)
  );

  // checks
  `TSV_ASSERT_NOW(a_model_last, clk, rst_n, out_tvalid && out_tuser[2], out_tlast, "model end off the third corner")
  `TSV_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "front took two triangles")
  `TSV_ASSERT_NEXT(a_corners_follow, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "triangle records broken up")

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsv_pkg::*;

  typedef struct {
    logic [31:0] color;
    logic [15:0] nx, ny, nz;
    logic [31:0] px, py, pz;
    logic [1:0]  corner;
    logic        last_corner;
    logic        last_model;
  } vertex_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic [OutUserW-1:0] out_tuser;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PaddrW-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // shadow of the block state
  logic [23:0] model_total = '0;
  logic [23:0] tri_count = '0;
  vertex_t     vertex_queue[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;

  triangle_to_shaded_vertices u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // true when d * sqrt(s) <= 255 * v
  function automatic bit chan_ok(longint d, longint v, longint unsigned s);
    longint unsigned d2, v2;
    if (d <= 0 && v >= 0) return 1'b1;
    if (d > 0 && v < 0) return 1'b0;
    d2 = d * d;
    v2 = v * v;
    if (d > 0) return d2 * s <= 65025 * v2;
    return d2 * s >= 65025 * v2;
  endfunction

  function automatic logic [7:0] shade_channel(longint v, longint unsigned s);
    if (s == 0) return ChanMid;
    for (int c = 255; c > 0; c--)
      if (chan_ok(2 * c - 255, v, s)) return c[7:0];
    return 8'd0;
  endfunction

  // expected vertices of one triangle
  task automatic predict_vertices(input logic [InDataW-1:0] tri_bits);
    longint x, y, z;
    longint unsigned s;
    logic [31:0] color;
    bit final_tri;
    vertex_t v;
    x = $signed(tri_bits[15:0]);
    y = $signed(tri_bits[31:16]);
    z = $signed(tri_bits[47:32]);
    s = x * x + y * y + z * z;
    color = {Alpha, shade_channel(z, s), shade_channel(y, s), shade_channel(x, s)};
    final_tri = (model_total != 0) && (tri_count == model_total - 24'd1);
    for (int k = 0; k < 3; k++) begin
      v.color = color;
      v.nx = tri_bits[15:0];
      v.ny = tri_bits[31:16];
      v.nz = tri_bits[47:32];
      v.px = tri_bits[48 + 96 * k +: 32];
      v.py = tri_bits[80 + 96 * k +: 32];
      v.pz = tri_bits[112 + 96 * k +: 32];
      v.corner = k[1:0];
      v.last_corner = (k == 2);
      v.last_model = (k == 2) && final_tri;
      vertex_queue.push_back(v);
    end
    tri_count = final_tri ? 24'd0 : tri_count + 24'd1;
  endtask

  // valid stays high between back-to-back transactions
  task automatic send_triangle(input logic [InDataW-1:0] tri_bits);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tri_bits;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_vertices(tri_bits);
  endtask

  task automatic make_triangle(input logic [15:0] nx, ny, nz,
                               output logic [InDataW-1:0] tri_bits);
    tri_bits[47:0] = {nz, ny, nx};
    for (int i = 0; i < 9; i++) tri_bits[48 + 32 * i +: 32] = $urandom;
  endtask

  task automatic drain_wait;
    in_tvalid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_total(input logic [23:0] total);
    drain_wait();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= RegTriangleTotal; cfg_pwdata <= {8'd0, total};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    model_total = total;
    tri_count = '0;
  endtask

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return $urandom_range(1) ? 16'h4000 : 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  // directed: extreme and zero normals, axis normals
  task automatic test_directed;
    logic [InDataW-1:0] t;
    logic [15:0] vals[6] = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0001};
    write_total(24'd4);
    for (int i = 0; i < 6; i++) begin
      make_triangle(vals[i], vals[(i + 1) % 6], vals[(i + 3) % 6], t);
      send_triangle(t);
    end
    make_triangle(16'h0, 16'h0, 16'h0, t);
    t[InDataW-1:48] = '1;
    send_triangle(t);
    t[InDataW-1:48] = '0;
    send_triangle(t);
    make_triangle(16'hffff, 16'h0, 16'h0, t);
    send_triangle(t);
    make_triangle(16'h0, 16'h0, 16'hffff, t);
    send_triangle(t);
  endtask

  // random triangles under a given model size
  task automatic test_random(input int n, input logic [23:0] total);
    logic [InDataW-1:0] t;
    write_total(total);
    for (int i = 0; i < n; i++) begin
      make_triangle(rand_normal(), rand_normal(), rand_normal(), t);
      send_triangle(t);
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full drain and four more triangles
  task automatic test_backpressure;
    logic [InDataW-1:0] t;
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) begin
      make_triangle(rand_normal(), rand_normal(), rand_normal(), t);
      send_triangle(t);
    end
    in_tvalid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      make_triangle(rand_normal(), rand_normal(), rand_normal(), t);
      send_triangle(t);
    end
  endtask

  // receiver ready pattern
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check each vertex transaction
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (vertex_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", out_tdata);
      end else begin
        e = vertex_queue.pop_front();
        if (out_tdata !== {e.pz, e.py, e.px, e.nz, e.ny, e.nx, e.color} ||
            out_tuser !== {e.last_model, e.corner} || out_tlast !== e.last_corner) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: exp %h %b %b got %h %b %b",
                     {e.pz, e.py, e.px, e.nz, e.ny, e.nx, e.color},
                     {e.last_model, e.corner}, e.last_corner,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 22; recv_idle_pct = 73;
    test_random(100, 24'd3);
    test_backpressure();
    send_idle_pct = 73; recv_idle_pct = 22;
    test_random(60, 24'd1);
    test_random(40, 24'hffffff);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(50, 24'd0);
    test_random(50, 24'd7);
    drain_wait();
    if (mismatches == 0) begin
      $display("triangle_to_shaded_vertices regression: pass");
    end else begin
      $display("triangle_to_shaded_vertices regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("triangle_to_shaded_vertices regression: fail");
    $finish;
  end

endmodule
